>>> hw/rtl/ctt_pkg.sv
`timescale 1ns / 1ps
// shared types, register map and constants of the crack tip extremum tracker
package ctt_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int DMG_W          = 17;
    localparam int DIR_W          = 3;
    localparam int RAD_W          = 31;
    localparam int SQ_W           = 2 * RAD_W;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;
    localparam int MID_DEPTH      = 4;
    localparam int OUT_DEPTH      = 2;

    localparam logic [DMG_W-1:0] DMG_LOW_RST  = 17'd16384;
    localparam logic [DMG_W-1:0] DMG_HIGH_RST = 17'd52429;
    localparam logic [1:0]       FRAMES_SAT   = 2'd2;

    // growth direction codes
    localparam logic [DIR_W-1:0] DIR_POS_X = 3'd0;
    localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd1;
    localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd3;
    localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd5;

    typedef enum logic [2:0] {
        REG_DAMAGE_LOW  = 3'd0,
        REG_DAMAGE_HIGH = 3'd1,
        REG_GROWTH_DIR  = 3'd2,
        REG_RADIUS      = 3'd3,
        REG_INIT_TIP_X  = 3'd4,
        REG_INIT_TIP_Y  = 3'd5,
        REG_INIT_TIP_Z  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic [DMG_W-1:0]          node_damage;
        logic signed [FIELD_W-1:0] node_x;
        logic signed [FIELD_W-1:0] node_y;
        logic signed [FIELD_W-1:0] node_z;
        logic                      frame_end;
    } t_node_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] tip_x;
        logic signed [FIELD_W-1:0] tip_y;
        logic signed [FIELD_W-1:0] tip_z;
        logic                      crack_found;
    } t_tip_out;

    typedef struct packed {
        logic [DMG_W-1:0] damage_low;
        logic [DMG_W-1:0] damage_high;
        logic [DIR_W-1:0] growth_direction;
        logic [RAD_W-1:0] search_radius;
    } t_cfg;

    // classification of one node, carried from front to back
    typedef struct packed {
        logic  dmg_ok;
        logic  positive;
        t_axis axis;
        logic  last;
    } t_cls_ctl;

endpackage

>>> hw/rtl/crack_tip_extremum_tracker_top.sv
`timescale 1ns / 1ps
// crack tip extremum tracker: top level
//
//  channel   direction  handshake                    payload
//  node      in         push / full                  i_node (t_node_in)
//  tip       out        pop / empty                  o_tip (t_tip_out)
//  config    in         psel penable pwrite pready   paddr, pwdata, prdata
//
// one node per cycle within a frame; a five-stage distance and extremum
// pipeline pushes a frame's tip to the result queue from its last stage;
// the next node waits for the new tip until the last node is in the last
// stage, or has left it if the next node is a last node too
// synchronous active-low reset restores register defaults and empties both
// queues; a full result queue stalls only a frame's last node
module crack_tip_extremum_tracker_top #(
    parameter int COORD_BITS = ctt_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ctt_pkg::ADDR_W-1:0]  paddr,
    input  logic [ctt_pkg::DATA_W-1:0]  pwdata,
    output logic [ctt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  ctt_pkg::t_node_in           i_node,
    output logic                        empty,
    input  logic                        pop,
    output ctt_pkg::t_tip_out           o_tip
);
    import ctt_pkg::*;

    localparam int CTL_W = $bits(t_cls_ctl);
    localparam int MID_W = CTL_W + 3 * COORD_BITS;
    localparam int OUT_W = $bits(t_tip_out);

    t_cfg                          cfg;
    logic signed [COORD_BITS-1:0]  init_x;
    logic signed [COORD_BITS-1:0]  init_y;
    logic signed [COORD_BITS-1:0]  init_z;
    logic [SQ_W-1:0]               rsq;

    t_cls_ctl                      f_ctl;
    logic signed [COORD_BITS-1:0]  f_x;
    logic signed [COORD_BITS-1:0]  f_y;
    logic signed [COORD_BITS-1:0]  f_z;

    logic [MID_W-1:0]              mid_wr;
    logic [MID_W-1:0]              mid_rd;
    logic                          mid_empty;
    logic                          mid_pop;

    logic                          out_push;
    logic                          out_full;
    t_tip_out                      out_tip;
    logic [OUT_W-1:0]              out_rd;

    ctt_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_init_x (init_x),
        .o_init_y (init_y),
        .o_init_z (init_z),
        .o_rsq    (rsq)
    );

    ctt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_node (i_node),
        .i_cfg  (cfg),
        .o_ctl  (f_ctl),
        .o_x    (f_x),
        .o_y    (f_y),
        .o_z    (f_z)
    );

    assign mid_wr = {f_ctl, f_x, f_y, f_z};

    ctt_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (mid_wr),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_rd),
        .o_empty (mid_empty)
    );

    ctt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!mid_empty),
        .i_ctl      (t_cls_ctl'(mid_rd[3*COORD_BITS +: CTL_W])),
        .i_x        (mid_rd[2*COORD_BITS +: COORD_BITS]),
        .i_y        (mid_rd[COORD_BITS +: COORD_BITS]),
        .i_z        (mid_rd[0 +: COORD_BITS]),
        .o_pop      (mid_pop),
        .i_cfg      (cfg),
        .i_init_x   (init_x),
        .i_init_y   (init_y),
        .i_init_z   (init_z),
        .i_rsq      (rsq),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_tip  (out_tip)
    );

    ctt_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_tip),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_rd),
        .o_empty (empty)
    );

    assign o_tip = t_tip_out'(out_rd);

endmodule

>>> hw/rtl/ctt_cfg.sv
`timescale 1ns / 1ps
// configuration registers behind the apb-style port
module ctt_cfg #(
    parameter int COORD_BITS = ctt_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ctt_pkg::ADDR_W-1:0]           paddr,
    input  logic [ctt_pkg::DATA_W-1:0]           pwdata,
    output logic [ctt_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready,
    output ctt_pkg::t_cfg                        o_cfg,
    output logic signed [COORD_BITS-1:0]         o_init_x,
    output logic signed [COORD_BITS-1:0]         o_init_y,
    output logic signed [COORD_BITS-1:0]         o_init_z,
    output logic [ctt_pkg::SQ_W-1:0]             o_rsq
);
    import ctt_pkg::*;

    logic [DMG_W-1:0]              r_dmg_low;
    logic [DMG_W-1:0]              r_dmg_high;
    logic [DIR_W-1:0]              r_dir;
    logic [RAD_W-1:0]              r_radius;
    logic signed [COORD_BITS-1:0]  r_init_x;
    logic signed [COORD_BITS-1:0]  r_init_y;
    logic signed [COORD_BITS-1:0]  r_init_z;
    logic [SQ_W-1:0]               r_rsq;
    logic                          wr_en;
    t_reg_idx                      idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmg_low  <= DMG_LOW_RST;
            r_dmg_high <= DMG_HIGH_RST;
            r_dir      <= DIR_POS_X;
            r_radius   <= '0;
            r_init_x   <= '0;
            r_init_y   <= '0;
            r_init_z   <= '0;
            r_rsq      <= '0;
        end else begin
            // squared radius is registered from the radius register and follows it in the next cycle
            r_rsq <= SQ_W'(r_radius) * SQ_W'(r_radius);
            if (wr_en) begin
                unique case (idx)
                    REG_DAMAGE_LOW:  r_dmg_low  <= pwdata[DMG_W-1:0];
                    REG_DAMAGE_HIGH: r_dmg_high <= pwdata[DMG_W-1:0];
                    REG_GROWTH_DIR:  r_dir      <= pwdata[DIR_W-1:0];
                    REG_RADIUS:      r_radius   <= pwdata[RAD_W-1:0];
                    REG_INIT_TIP_X:  r_init_x   <= pwdata[COORD_BITS-1:0];
                    REG_INIT_TIP_Y:  r_init_y   <= pwdata[COORD_BITS-1:0];
                    REG_INIT_TIP_Z:  r_init_z   <= pwdata[COORD_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (idx)
            REG_DAMAGE_LOW:  prdata = DATA_W'(r_dmg_low);
            REG_DAMAGE_HIGH: prdata = DATA_W'(r_dmg_high);
            REG_GROWTH_DIR:  prdata = DATA_W'(r_dir);
            REG_RADIUS:      prdata = DATA_W'(r_radius);
            REG_INIT_TIP_X:  prdata = DATA_W'(r_init_x);
            REG_INIT_TIP_Y:  prdata = DATA_W'(r_init_y);
            REG_INIT_TIP_Z:  prdata = DATA_W'(r_init_z);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.damage_low       = r_dmg_low;
    assign o_cfg.damage_high      = r_dmg_high;
    assign o_cfg.growth_direction = r_dir;
    assign o_cfg.search_radius    = r_radius;
    assign o_init_x               = r_init_x;
    assign o_init_y               = r_init_y;
    assign o_init_z               = r_init_z;
    assign o_rsq                  = r_rsq;

endmodule

>>> hw/rtl/ctt_fifo.sv
`timescale 1ns / 1ps
// small register queue with push/full and pop/empty sides
module ctt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             wr_en;
    logic             rd_en;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= next_ptr(r_wr);
            end
            if (rd_en) begin
                r_rd <= next_ptr(r_rd);
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> hw/rtl/ctt_front.sv
`timescale 1ns / 1ps
// front end: damage window test and growth axis decode for each node
module ctt_front #(
    parameter int COORD_BITS = ctt_pkg::COORD_BITS_DEF
) (
    input  ctt_pkg::t_node_in            i_node,
    input  ctt_pkg::t_cfg                i_cfg,
    output ctt_pkg::t_cls_ctl            o_ctl,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic signed [COORD_BITS-1:0] o_z
);
    import ctt_pkg::*;

    always_comb begin
        o_ctl.dmg_ok = (i_node.node_damage >= i_cfg.damage_low) &&
                       (i_node.node_damage <= i_cfg.damage_high);
        o_ctl.last   = i_node.frame_end;
        unique case (i_cfg.growth_direction)
            DIR_POS_X: begin o_ctl.axis = AXIS_X; o_ctl.positive = 1'b1; end
            DIR_POS_Y: begin o_ctl.axis = AXIS_Y; o_ctl.positive = 1'b1; end
            DIR_POS_Z: begin o_ctl.axis = AXIS_Z; o_ctl.positive = 1'b1; end
            DIR_NEG_X: begin o_ctl.axis = AXIS_X; o_ctl.positive = 1'b0; end
            DIR_NEG_Y: begin o_ctl.axis = AXIS_Y; o_ctl.positive = 1'b0; end
            DIR_NEG_Z: begin o_ctl.axis = AXIS_Z; o_ctl.positive = 1'b0; end
            // unused codes behave as +x
            default:   begin o_ctl.axis = AXIS_X; o_ctl.positive = 1'b1; end
        endcase
    end

    // only the low coordinate bits count, read as two's complement
    assign o_x = i_node.node_x[COORD_BITS-1:0];
    assign o_y = i_node.node_y[COORD_BITS-1:0];
    assign o_z = i_node.node_z[COORD_BITS-1:0];

endmodule

>>> hw/rtl/ctt_back.sv
`timescale 1ns / 1ps
// back end: distance pipeline to the previous tip and running extremum
module ctt_back #(
    parameter int COORD_BITS = ctt_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  ctt_pkg::t_cls_ctl             i_ctl,
    input  logic signed [COORD_BITS-1:0]  i_x,
    input  logic signed [COORD_BITS-1:0]  i_y,
    input  logic signed [COORD_BITS-1:0]  i_z,
    output logic                          o_pop,
    input  ctt_pkg::t_cfg                 i_cfg,
    input  logic signed [COORD_BITS-1:0]  i_init_x,
    input  logic signed [COORD_BITS-1:0]  i_init_y,
    input  logic signed [COORD_BITS-1:0]  i_init_z,
    input  logic [ctt_pkg::SQ_W-1:0]      i_rsq,
    input  logic                          i_out_full,
    output logic                          o_out_push,
    output ctt_pkg::t_tip_out             o_out_tip
);
    import ctt_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int CMP_W = (CB > RAD_W) ? CB : RAD_W;
    localparam int SXY_W = SQ_W + 1;
    localparam int T_W   = SQ_W + 2;
    localparam int NSTG  = 5;

    // stage k of the pipeline sits in index k-1
    logic [NSTG-1:0]        r_vld;
    t_cls_ctl               r_ctl [NSTG];
    logic signed [CB-1:0]   r_c   [NSTG][3];

    logic signed [DW-1:0]   r_dpos [3];
    logic signed [DW-1:0]   r_dneg [3];
    logic [RAD_W-1:0]       r_mop  [3];
    logic [SQ_W-1:0]        r_sq   [3];
    logic                   r_inr3;
    logic                   r_inr4;
    logic                   r_inr5;
    logic [SXY_W-1:0]       r_sxy;
    logic [T_W-1:0]         r_t;

    logic signed [CB-1:0]   r_prev [3];
    logic signed [CB-1:0]   r_best [3];
    logic signed [CB-1:0]   r_best_key;
    logic                   r_have;
    logic [1:0]             r_frames;

    logic                   frame_busy;
    logic                   issue;
    logic [CMP_W-1:0]       abs_ext [3];
    logic [2:0]             inr;
    logic signed [CB-1:0]   init [3];
    logic signed [CB-1:0]   key_node;
    logic signed [CB-1:0]   key_best;
    logic                   rad_ok;
    logic                   node_ok;
    logic                   better;
    logic                   upd;
    logic                   cand_have;
    logic signed [CB-1:0]   cand [3];
    logic signed [CB-1:0]   tip  [3];
    logic                   frame_done;

    // a new frame may not start its distance test until the tip it needs is out
    assign frame_busy = (r_vld[0] && r_ctl[0].last) || (r_vld[1] && r_ctl[1].last) ||
                        (r_vld[2] && r_ctl[2].last) || (r_vld[3] && r_ctl[3].last);
    assign issue      = i_valid && !frame_busy &&
                        !(i_ctl.last && (i_out_full || (r_vld[4] && r_ctl[4].last)));
    assign o_pop      = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], issue};
        end
    end

    // payload travelling alongside the valid bits
    always_ff @(posedge i_clk) begin
        r_ctl[0]    <= i_ctl;
        r_c[0][0]   <= i_x;
        r_c[0][1]   <= i_y;
        r_c[0][2]   <= i_z;
        for (int k = 1; k < NSTG; k++) begin
            r_ctl[k] <= r_ctl[k-1];
            r_c[k]   <= r_c[k-1];
        end
    end

    // stage 1: differences both ways to the previous tip
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_dpos[a] <= DW'(r_c[0][a]) - DW'(r_prev[a]);
            r_dneg[a] <= DW'(r_prev[a]) - DW'(r_c[0][a]);
        end
    end

    // stage 2: magnitude and per-axis bound against the radius
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            abs_ext[a] = r_dpos[a][DW-1] ? CMP_W'(r_dneg[a][CB-1:0])
                                         : CMP_W'(r_dpos[a][CB-1:0]);
            inr[a]     = abs_ext[a] < CMP_W'(i_cfg.search_radius);
        end
    end

    always_ff @(posedge i_clk) begin
        r_inr3 <= &inr;
        for (int a = 0; a < 3; a++) begin
            r_mop[a] <= abs_ext[a][RAD_W-1:0];
        end
    end

    // stage 3: squares, operands below the radius when they matter
    always_ff @(posedge i_clk) begin
        r_inr4 <= r_inr3;
        for (int a = 0; a < 3; a++) begin
            r_sq[a] <= SQ_W'(r_mop[a]) * SQ_W'(r_mop[a]);
        end
    end

    // stage 4: x and y sum, and what is left of r squared after z
    always_ff @(posedge i_clk) begin
        r_inr5 <= r_inr4;
        r_sxy  <= SXY_W'(r_sq[0]) + SXY_W'(r_sq[1]);
        r_t    <= T_W'(i_rsq) - T_W'(r_sq[2]);
    end

    // stage 5: qualify and update the running extremum
    assign init[0] = i_init_x;
    assign init[1] = i_init_y;
    assign init[2] = i_init_z;

    always_comb begin
        unique case (r_ctl[4].axis)
            AXIS_X: begin key_node = r_c[4][0]; end
            AXIS_Y: begin key_node = r_c[4][1]; end
            AXIS_Z: begin key_node = r_c[4][2]; end
            default: begin key_node = r_c[4][0]; end
        endcase
    end

    assign key_best = r_best_key;

    // negative remainder means the sum is already too large
    assign rad_ok     = r_inr5 && !r_t[T_W-1] && (r_sxy < r_t[SXY_W-1:0]);
    assign node_ok    = r_ctl[4].dmg_ok && ((r_frames != FRAMES_SAT) || rad_ok);
    assign better     = !r_have || (r_ctl[4].positive ? (key_node > key_best)
                                                      : (key_node < key_best));
    assign upd        = r_vld[4] && node_ok && better;
    assign cand_have  = r_have || upd;
    assign frame_done = r_vld[4] && r_ctl[4].last;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            cand[a] = upd ? r_c[4][a] : r_best[a];
            tip[a]  = cand_have ? cand[a] : init[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_frames   <= '0;
            r_best_key <= '0;
            for (int a = 0; a < 3; a++) begin
                r_prev[a] <= '0;
                r_best[a] <= '0;
            end
        end else if (frame_done) begin
            r_have     <= 1'b0;
            r_best_key <= '0;
            if (r_frames != FRAMES_SAT) begin
                r_frames <= r_frames + 2'd1;
            end
            for (int a = 0; a < 3; a++) begin
                r_prev[a] <= tip[a];
                r_best[a] <= '0;
            end
        end else if (upd) begin
            r_have     <= 1'b1;
            r_best_key <= key_node;
            for (int a = 0; a < 3; a++) begin
                r_best[a] <= r_c[4][a];
            end
        end
    end

    assign o_out_push = frame_done;

    always_comb begin
        o_out_tip.tip_x       = FIELD_W'(tip[0]);
        o_out_tip.tip_y       = FIELD_W'(tip[1]);
        o_out_tip.tip_z       = FIELD_W'(tip[2]);
        o_out_tip.crack_found = cand_have;
    end

endmodule

>>> hw/rtl/ctt_checker.sv
`timescale 1ns / 1ps
// port-level checks of the tracker and their binding to the top level
module ctt_checker #(
    parameter int COORD_BITS = ctt_pkg::COORD_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [ctt_pkg::ADDR_W-1:0]  paddr,
    input logic [ctt_pkg::DATA_W-1:0]  pwdata,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input ctt_pkg::t_tip_out           o_tip
);
    import ctt_pkg::*;

    logic signed [FIELD_W-1:0] r_init [3];
    logic                      wr_en;
    t_reg_idx                  idx;
    logic signed [FIELD_W-1:0] wr_coord;

    assign wr_en    = psel && penable && pwrite;
    assign idx      = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_coord = FIELD_W'($signed(pwdata[COORD_BITS-1:0]));

    // shadow of the precrack tip as written on the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_init[a] <= '0;
            end
        end else if (wr_en) begin
            if (idx == REG_INIT_TIP_X) begin
                r_init[0] <= wr_coord;
            end
            if (idx == REG_INIT_TIP_Y) begin
                r_init[1] <= wr_coord;
            end
            if (idx == REG_INIT_TIP_Z) begin
                r_init[2] <= wr_coord;
            end
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full && !push |=> !full)
        else $error("node queue filled without a push");

    a_tip_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_tip))
        else $error("waiting tip changed or vanished");

    a_no_crack_initial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_tip.crack_found |->
            (o_tip.tip_x == r_init[0]) && (o_tip.tip_y == r_init[1]) &&
            (o_tip.tip_z == r_init[2]))
        else $error("tip without a crack is not the precrack tip");

endmodule

bind crack_tip_extremum_tracker_top ctt_checker #(
    .COORD_BITS (COORD_BITS)
) u_ctt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_tip   (o_tip)
);
